// ===== sv/assert_macros.svh =====
// Assertion macros for the score function unit RTL (used by isf_ctrl).
// Define NO_ASSERTIONS to compile the checks out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// Same-cycle implication, disabled in reset
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("implication check failed");
// Next-cycle implication, disabled in reset
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");
`else
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ===== sv/isf_pkg.sv =====
// Package for the ICA score function unit: widths, FSM and command types,
// and the tanh / log cosh lookup tables built at elaboration.
// No dependencies.
package isf_pkg;

    localparam int MAX_SAMPLES = 65536;
    localparam int TABLE_DEPTH = 1024;

    localparam int Z_W     = 16;
    localparam int K_W     = 2;
    localparam int PHI_W   = 17;
    localparam int DPHI_W  = 13;
    localparam int MEAN_W  = 24;
    localparam int SUM_W   = 40;
    localparam int CNT_W   = $clog2(MAX_SAMPLES + 1);
    localparam int IDX_W   = $clog2(TABLE_DEPTH);
    localparam int TANH_W  = 12;
    localparam int LCOSH_W = 16;
    localparam int LOGP_W  = 21;
    localparam int HZ_W    = 20;
    localparam int IPROD_W = Z_W + 1 + IDX_W + 2;
    localparam int DIV_W   = SUM_W + 1;
    localparam int STEP_W  = $clog2(DIV_W + 1);

    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;

    // Register index codes (byte address bit 2)
    localparam logic REG_MODE = 1'b0;
    localparam logic MODE_RESET = 1'b1;
    localparam logic MODE_EXTENDED = 1'b1;

    // Sign codes of k
    localparam logic [K_W-1:0] K_ZERO    = 2'b00;
    localparam logic [K_W-1:0] K_POS     = 2'b01;
    localparam logic [K_W-1:0] K_NEG     = 2'b11;
    localparam logic [K_W-1:0] K_NEG_TWO = 2'b10;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_CALC,
        ST_ACC,
        ST_DIVGO,
        ST_DIV,
        ST_DONE
    } isf_state_t;

    typedef struct packed {
        logic load_in;
        logic read_rom;
        logic calc;
        logic acc;
        logic div_start;
        logic load_out;
    } isf_cmd_t;

    typedef struct packed {
        logic last;
        logic div_done;
        logic out_free;
    } isf_status_t;

    typedef logic [TANH_W-1:0]  tanh_rom_t  [TABLE_DEPTH];
    typedef logic [LCOSH_W-1:0] lcosh_rom_t [TABLE_DEPTH];

    // tanh of grid point x (Q11) in Q30, via exp(-2x) from repeated squaring
    function automatic logic [63:0] tanh_q30(input logic [31:0] x);
        logic [63:0] base [15];
        logic [63:0] e;
        logic [63:0] num;
        logic [63:0] den;
        logic [63:0] rem;
        logic [63:0] quo;
        base[0] = 64'd1072693760;
        for (int j = 1; j < 15; j++)
        begin
            base[j] = (base[j-1] * base[j-1] + (64'd1 << 29)) >> 30;
        end
        e = 64'd1 << 30;
        for (int j = 0; j < 15; j++)
        begin
            if (x[j])
            begin
                e = (e * base[j] + (64'd1 << 29)) >> 30;
            end
        end
        num = ((64'd1 << 30) - e) << 30;
        den = (64'd1 << 30) + e;
        rem = '0;
        quo = '0;
        // long division, one quotient bit a step
        for (int b = 63; b >= 0; b--)
        begin
            rem = {rem[62:0], num[b]};
            if (rem >= den)
            begin
                rem    = rem - den;
                quo[b] = 1'b1;
            end
        end
        return quo;
    endfunction

    function automatic logic [31:0] grid_x(input int i);
        return 32'((64'(i) * 64'd32768) / TABLE_DEPTH);
    endfunction

    function automatic tanh_rom_t build_tanh_rom();
        tanh_rom_t   rom;
        logic [63:0] t;
        for (int i = 0; i < TABLE_DEPTH; i++)
        begin
            t      = tanh_q30(grid_x(i));
            rom[i] = TANH_W'((t + (64'd1 << 18)) >> 19);
        end
        return rom;
    endfunction

    // log cosh as a running trapezoid sum of tanh over the grid
    function automatic lcosh_rom_t build_lcosh_rom();
        lcosh_rom_t  rom;
        logic [63:0] t;
        logic [63:0] prev_t;
        logic [63:0] acc;
        logic [31:0] x;
        logic [31:0] prev_x;
        prev_t = '0;
        prev_x = '0;
        acc    = '0;
        for (int i = 0; i < TABLE_DEPTH; i++)
        begin
            x = grid_x(i);
            t = tanh_q30(x);
            if (i > 0)
            begin
                acc = acc + ((64'(x - prev_x) * (prev_t + t) + 64'd2048) >> 12);
            end
            rom[i] = LCOSH_W'((acc + (64'd1 << 18)) >> 19);
            prev_t = t;
            prev_x = x;
        end
        return rom;
    endfunction

    localparam tanh_rom_t  TANH_ROM  = build_tanh_rom();
    localparam lcosh_rom_t LCOSH_ROM = build_lcosh_rom();

endpackage

// ===== sv/isf_in_if.sv =====
// Sample input channel: valid/ready handshake with z, k and last mark.
// Depends on isf_pkg.
interface isf_in_if;
    logic                        valid;
    logic                        ready;
    logic signed [isf_pkg::Z_W-1:0] z_sample;
    logic signed [isf_pkg::K_W-1:0] k_sign;
    logic                        last_sample;

    modport source (output valid, output z_sample, output k_sign, output last_sample,
                    input ready);
    modport sink (input valid, input z_sample, input k_sign, input last_sample,
                  output ready);
endinterface

// ===== sv/isf_out_if.sv =====
// Result output channel: valid/ready handshake with phi, dphi and the mean.
// Depends on isf_pkg.
interface isf_out_if;
    logic                              valid;
    logic                              ready;
    logic signed [isf_pkg::PHI_W-1:0]  phi_value;
    logic [isf_pkg::DPHI_W-1:0]        dphi_value;
    logic signed [isf_pkg::MEAN_W-1:0] mean_neg_logp;
    logic                              mean_valid;

    modport source (output valid, output phi_value, output dphi_value,
                    output mean_neg_logp, output mean_valid, input ready);
    modport sink (input valid, input phi_value, input dphi_value,
                  input mean_neg_logp, input mean_valid, output ready);
endinterface

// ===== sv/ica_score_function_unit.sv =====
// ICA score function unit, top level: APB mode register, controller, datapath.
// A sample passes through the states READ, CALC, ACC and DONE after its input transfer;
// a last sample also runs DIVGO and DIV (41-step bit-serial mean divider) before DONE.
// The datapath is shared and sequenced: a new sample is taken only in IDLE, after the last result is loaded.
// Reset (rst_n, async, active low): mode = extended, logp sum and count zero.
// Depends on isf_pkg, isf_in_if, isf_out_if, isf_ctrl, isf_datapath.
module ica_score_function_unit
(
    input  logic                              clk,
    input  logic                              rst_n,
    isf_in_if.sink                            sample_in,
    isf_out_if.source                         result_out,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [isf_pkg::APB_ADDR_W-1:0]    paddr,
    input  logic [isf_pkg::APB_DATA_W-1:0]    pwdata,
    output logic [isf_pkg::APB_DATA_W-1:0]    prdata,
    output logic                              pready
);

    logic                 mode_reg;
    logic                 mode_next;
    logic                 in_ready;
    isf_pkg::isf_cmd_t    cmd;
    isf_pkg::isf_status_t status;

    // Mode register write and read-back
    always_comb
    begin
        mode_next = mode_reg;
        if (psel && penable && pwrite && (paddr[2] == isf_pkg::REG_MODE))
        begin
            mode_next = pwdata[0];
        end
        prdata = (paddr[2] == isf_pkg::REG_MODE)
                 ? {{(isf_pkg::APB_DATA_W-1){1'b0}}, mode_reg} : '0;
    end

    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= isf_pkg::MODE_RESET;
        end
        else
        begin
            mode_reg <= mode_next;
        end
    end

    isf_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (sample_in.valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    isf_datapath u_dp
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .mode          (mode_reg),
        .cmd           (cmd),
        .status        (status),
        .z_sample      (sample_in.z_sample),
        .k_sign        (sample_in.k_sign),
        .last_sample   (sample_in.last_sample),
        .out_valid     (result_out.valid),
        .out_ready     (result_out.ready),
        .phi_value     (result_out.phi_value),
        .dphi_value    (result_out.dphi_value),
        .mean_neg_logp (result_out.mean_neg_logp),
        .mean_valid    (result_out.mean_valid)
    );

    assign sample_in.ready = in_ready;

endmodule

// ===== sv/isf_divider.sv =====
// Restoring divider, one quotient bit per cycle, for the component mean.
// Depends on isf_pkg.
module isf_divider
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [isf_pkg::DIV_W-1:0]  dividend,
    input  logic [isf_pkg::CNT_W-1:0]  divisor,
    output logic                       done,
    output logic [isf_pkg::DIV_W-1:0]  quotient
);

    logic [isf_pkg::CNT_W:0]    rem_reg;
    logic [isf_pkg::CNT_W:0]    rem_next;
    logic [isf_pkg::DIV_W-1:0]  quo_reg;
    logic [isf_pkg::DIV_W-1:0]  quo_next;
    logic [isf_pkg::CNT_W-1:0]  dsr_reg;
    logic [isf_pkg::STEP_W-1:0] step_reg;
    logic [isf_pkg::STEP_W-1:0] step_next;
    logic                       busy_reg;
    logic                       busy_next;
    logic                       done_reg;
    logic                       done_next;
    logic [isf_pkg::CNT_W:0]    rem_sh;
    logic                       fits;

    // Shift in one dividend bit and try the subtraction
    always_comb
    begin
        rem_sh    = {rem_reg[isf_pkg::CNT_W-1:0], quo_reg[isf_pkg::DIV_W-1]};
        fits      = rem_sh >= {1'b0, dsr_reg};
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        step_next = step_reg;
        busy_next = busy_reg;
        done_next = done_reg;
        if (start)
        begin
            rem_next  = '0;
            quo_next  = dividend;
            step_next = '0;
            busy_next = 1'b1;
            done_next = 1'b0;
        end
        else if (busy_reg)
        begin
            rem_next  = fits ? (rem_sh - {1'b0, dsr_reg}) : rem_sh;
            quo_next  = {quo_reg[isf_pkg::DIV_W-2:0], fits};
            step_next = step_reg + 1'b1;
            if (step_reg == isf_pkg::STEP_W'(isf_pkg::DIV_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        if (start)
        begin
            dsr_reg <= divisor;
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

// ===== sv/isf_datapath.sv =====
// Datapath of the score function unit: table lookup, phi/dphi/logp arithmetic,
// logp accumulation, mean division and the output register.
// Depends on isf_pkg and isf_divider.
module isf_datapath
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               mode,
    input  isf_pkg::isf_cmd_t                  cmd,
    output isf_pkg::isf_status_t               status,
    input  logic signed [isf_pkg::Z_W-1:0]     z_sample,
    input  logic signed [isf_pkg::K_W-1:0]     k_sign,
    input  logic                               last_sample,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic signed [isf_pkg::PHI_W-1:0]   phi_value,
    output logic [isf_pkg::DPHI_W-1:0]         dphi_value,
    output logic signed [isf_pkg::MEAN_W-1:0]  mean_neg_logp,
    output logic                               mean_valid
);

    localparam int ZE_W = isf_pkg::Z_W + 2;
    localparam logic signed [ZE_W-1:0] PHI_MAX = ZE_W'(2 ** (isf_pkg::PHI_W - 1) - 1);
    localparam logic signed [ZE_W-1:0] PHI_MIN = -ZE_W'(2 ** (isf_pkg::PHI_W - 1));
    localparam logic [isf_pkg::DIV_W-1:0] MEAN_MAG = isf_pkg::DIV_W'(2 ** (isf_pkg::MEAN_W - 1));
    localparam logic [isf_pkg::DPHI_W-1:0] DPHI_ONE = isf_pkg::DPHI_W'(2048);

    // Input stage
    logic signed [isf_pkg::Z_W-1:0]  z_reg;
    logic                            kpos_reg;
    logic                            kneg_reg;
    logic                            last_reg;
    logic [isf_pkg::IDX_W-1:0]       idx_reg;
    logic [isf_pkg::IDX_W-1:0]       idx_next;
    logic signed [isf_pkg::Z_W:0]    zx;
    logic [isf_pkg::Z_W:0]           az;
    logic [isf_pkg::IPROD_W-1:0]     iprod;
    logic [isf_pkg::IPROD_W-1:0]     iraw;

    // Lookup stage
    logic [isf_pkg::TANH_W-1:0]      t_reg;
    logic [isf_pkg::LCOSH_W-1:0]     lc_reg;
    logic [2*isf_pkg::Z_W-1:0]       zz_reg;

    // Arithmetic stage
    logic [2*isf_pkg::TANH_W-1:0]    tt;
    logic [isf_pkg::DPHI_W-1:0]      tq_next;
    logic [isf_pkg::DPHI_W-1:0]      tq_reg;
    logic signed [isf_pkg::TANH_W:0] tz;
    logic signed [isf_pkg::TANH_W:0] ktz;
    logic signed [ZE_W-1:0]          phi_ext;
    logic signed [isf_pkg::PHI_W-1:0] phi_next;
    logic signed [isf_pkg::PHI_W-1:0] phi_reg;
    logic [2*isf_pkg::Z_W-1:0]       zz_rnd;
    logic [isf_pkg::HZ_W-1:0]        half_zz;
    logic signed [isf_pkg::LCOSH_W:0] klc;
    logic signed [isf_pkg::LOGP_W-1:0] logp_next;
    logic signed [isf_pkg::LOGP_W-1:0] logp_reg;
    logic [isf_pkg::DPHI_W-1:0]      dphi_next;
    logic [isf_pkg::DPHI_W-1:0]      dphi_reg;

    // Accumulator and mean
    logic signed [isf_pkg::SUM_W-1:0] sum_reg;
    logic signed [isf_pkg::SUM_W-1:0] sum_next;
    logic [isf_pkg::CNT_W-1:0]        cnt_reg;
    logic [isf_pkg::CNT_W-1:0]        cnt_next;
    logic signed [isf_pkg::DIV_W-1:0] sx;
    logic [isf_pkg::DIV_W-1:0]        mag;
    logic [isf_pkg::DIV_W-1:0]        dividend;
    logic                             neg_reg;
    logic                             div_done;
    logic [isf_pkg::DIV_W-1:0]        quotient;
    logic [isf_pkg::DIV_W-1:0]        q_sat;
    logic signed [isf_pkg::MEAN_W-1:0] mean_calc;

    // Output register
    logic                              out_valid_reg;
    logic                              out_valid_next;
    logic signed [isf_pkg::PHI_W-1:0]  phi_out_reg;
    logic [isf_pkg::DPHI_W-1:0]        dphi_out_reg;
    logic signed [isf_pkg::MEAN_W-1:0] mean_out_reg;
    logic                              mvalid_out_reg;

    // Table index: round(|z| * depth / 32768), clamped to the last entry
    always_comb
    begin
        zx    = {z_sample[isf_pkg::Z_W-1], z_sample};
        az    = zx[isf_pkg::Z_W] ? $unsigned(-zx) : $unsigned(zx);
        iprod = isf_pkg::IPROD_W'(az) * isf_pkg::IPROD_W'(isf_pkg::TABLE_DEPTH)
                + isf_pkg::IPROD_W'(16384);
        iraw  = iprod >> 15;
        if (iraw >= isf_pkg::IPROD_W'(isf_pkg::TABLE_DEPTH))
        begin
            idx_next = isf_pkg::IDX_W'(isf_pkg::TABLE_DEPTH - 1);
        end
        else
        begin
            idx_next = iraw[isf_pkg::IDX_W-1:0];
        end
    end

    // phi, t^2 and logp
    always_comb
    begin
        tt      = t_reg * t_reg;
        tq_next = isf_pkg::DPHI_W'((tt + (2*isf_pkg::TANH_W)'(1024)) >> 11);
        tz      = z_reg[isf_pkg::Z_W-1] ? -$signed({1'b0, t_reg}) : $signed({1'b0, t_reg});
        ktz     = kpos_reg ? tz : (kneg_reg ? -tz : '0);
        phi_ext = ZE_W'(z_reg) + ZE_W'(ktz);
        if (mode != isf_pkg::MODE_EXTENDED)
        begin
            phi_next = isf_pkg::PHI_W'(tz);
        end
        else if (phi_ext > PHI_MAX)
        begin
            phi_next = isf_pkg::PHI_W'(PHI_MAX);
        end
        else if (phi_ext < PHI_MIN)
        begin
            phi_next = isf_pkg::PHI_W'(PHI_MIN);
        end
        else
        begin
            phi_next = isf_pkg::PHI_W'(phi_ext);
        end
        zz_rnd  = zz_reg + (2*isf_pkg::Z_W)'(2048);
        half_zz = zz_rnd[isf_pkg::HZ_W+11:12];
        klc     = kpos_reg ? $signed({1'b0, lc_reg})
                           : (kneg_reg ? -$signed({1'b0, lc_reg}) : '0);
        if (mode == isf_pkg::MODE_EXTENDED)
        begin
            logp_next = isf_pkg::LOGP_W'($signed({1'b0, half_zz}))
                        + isf_pkg::LOGP_W'(klc);
        end
        else
        begin
            logp_next = isf_pkg::LOGP_W'($signed({1'b0, lc_reg}));
        end
    end

    // dphi from t^2
    always_comb
    begin
        if (mode != isf_pkg::MODE_EXTENDED)
        begin
            dphi_next = DPHI_ONE - tq_reg;
        end
        else if (kpos_reg)
        begin
            dphi_next = (DPHI_ONE << 1) - tq_reg;
        end
        else if (kneg_reg)
        begin
            dphi_next = tq_reg;
        end
        else
        begin
            dphi_next = DPHI_ONE;
        end
    end

    // Accumulate until the component is full, clear on division start
    always_comb
    begin
        sum_next = sum_reg;
        cnt_next = cnt_reg;
        if (cmd.div_start)
        begin
            sum_next = '0;
            cnt_next = '0;
        end
        else if (cmd.acc && (cnt_reg < isf_pkg::CNT_W'(isf_pkg::MAX_SAMPLES)))
        begin
            sum_next = sum_reg + isf_pkg::SUM_W'(logp_reg);
            cnt_next = cnt_reg + 1'b1;
        end
    end

    // Divider operands: |sum| + count/2 over count
    always_comb
    begin
        sx       = isf_pkg::DIV_W'(sum_reg);
        mag      = sx[isf_pkg::DIV_W-1] ? $unsigned(-sx) : $unsigned(sx);
        dividend = mag + isf_pkg::DIV_W'(cnt_reg >> 1);
    end

    isf_divider u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (dividend),
        .divisor  (cnt_reg),
        .done     (div_done),
        .quotient (quotient)
    );

    // Saturate the mean and give it the sign of -sum
    always_comb
    begin
        q_sat = (quotient > MEAN_MAG) ? MEAN_MAG : quotient;
        if (neg_reg)
        begin
            mean_calc = (q_sat == MEAN_MAG) ? isf_pkg::MEAN_W'(MEAN_MAG - 1'b1)
                                            : isf_pkg::MEAN_W'(q_sat);
        end
        else
        begin
            mean_calc = -isf_pkg::MEAN_W'(q_sat);
        end
    end

    // Output valid: set on load, drop on transfer
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg       <= '0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            sum_reg       <= sum_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers, advanced by controller commands
    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            z_reg    <= z_sample;
            kpos_reg <= (k_sign == isf_pkg::K_POS);
            kneg_reg <= k_sign[isf_pkg::K_W-1];
            last_reg <= last_sample;
            idx_reg  <= idx_next;
        end
        if (cmd.read_rom)
        begin
            t_reg  <= isf_pkg::TANH_ROM[idx_reg];
            lc_reg <= isf_pkg::LCOSH_ROM[idx_reg];
            zz_reg <= (2*isf_pkg::Z_W)'(z_reg * z_reg);
        end
        if (cmd.calc)
        begin
            tq_reg   <= tq_next;
            phi_reg  <= phi_next;
            logp_reg <= logp_next;
        end
        if (cmd.acc)
        begin
            dphi_reg <= dphi_next;
        end
        if (cmd.div_start)
        begin
            neg_reg <= sum_reg[isf_pkg::SUM_W-1];
        end
        if (cmd.load_out)
        begin
            phi_out_reg    <= phi_reg;
            dphi_out_reg   <= dphi_reg;
            mean_out_reg   <= last_reg ? mean_calc : '0;
            mvalid_out_reg <= last_reg;
        end
    end

    always_comb
    begin
        status.last     = last_reg;
        status.div_done = div_done;
        status.out_free = !out_valid_reg || out_ready;
    end

    assign out_valid     = out_valid_reg;
    assign phi_value     = phi_out_reg;
    assign dphi_value    = dphi_out_reg;
    assign mean_neg_logp = mean_out_reg;
    assign mean_valid    = mvalid_out_reg;

endmodule

// ===== sv/isf_ctrl.sv =====
// Controller state machine: sequences lookup, arithmetic, accumulation,
// the mean division and the output load. Depends on isf_pkg, assert_macros.svh.
`include "assert_macros.svh"
module isf_ctrl
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  isf_pkg::isf_status_t  status,
    output isf_pkg::isf_cmd_t     cmd
);

    isf_pkg::isf_state_t state_reg;
    isf_pkg::isf_state_t state_next;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            isf_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = isf_pkg::ST_READ;
                end
            end
            isf_pkg::ST_READ:  state_next = isf_pkg::ST_CALC;
            isf_pkg::ST_CALC:  state_next = isf_pkg::ST_ACC;
            isf_pkg::ST_ACC:
            begin
                state_next = status.last ? isf_pkg::ST_DIVGO : isf_pkg::ST_DONE;
            end
            isf_pkg::ST_DIVGO: state_next = isf_pkg::ST_DIV;
            isf_pkg::ST_DIV:
            begin
                if (status.div_done)
                begin
                    state_next = isf_pkg::ST_DONE;
                end
            end
            isf_pkg::ST_DONE:
            begin
                if (status.out_free)
                begin
                    state_next = isf_pkg::ST_IDLE;
                end
            end
            default: state_next = isf_pkg::ST_IDLE;
        endcase
    end

    // Commands
    always_comb
    begin
        cmd      = '0;
        in_ready = 1'b0;
        unique case (state_reg)
            isf_pkg::ST_IDLE:
            begin
                in_ready    = 1'b1;
                cmd.load_in = in_valid;
            end
            isf_pkg::ST_READ:  cmd.read_rom  = 1'b1;
            isf_pkg::ST_CALC:  cmd.calc      = 1'b1;
            isf_pkg::ST_ACC:   cmd.acc       = 1'b1;
            isf_pkg::ST_DIVGO: cmd.div_start = 1'b1;
            isf_pkg::ST_DIV:   cmd          = '0;
            isf_pkg::ST_DONE:  cmd.load_out  = status.out_free;
            default:           cmd          = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= isf_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    `ASSERT_IMPLY(a_load_needs_room, clk, rst_n, cmd.load_out, status.out_free)
    `ASSERT_NEXT(a_accept_to_read, clk, rst_n, cmd.load_in, state_reg == isf_pkg::ST_READ)
    `ASSERT_NEXT(a_div_runs, clk, rst_n, cmd.div_start, !status.div_done)

endmodule
